FILE: design/hqi_pkg.sv
// ---------------------------------------------------------------------------
// hqi_pkg: shared types and constants of the hybrid sorter
// Element width, store depth, cell link and control structs, and the
// one-hot state codes of the sequencer.
// ---------------------------------------------------------------------------
package hqi_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int DATA_WIDTH   = 32;
   localparam int COUNT_WIDTH  = $clog2(MAX_ELEMENTS + 1);
   localparam int CUTOFF_WIDTH = 7;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic [COUNT_WIDTH-1:0]       count_type;
   typedef logic [CUTOFF_WIDTH-1:0]      cutoff_type;

   // what one cell shows to its neighbors
   typedef struct packed {
      logic     valid;
      logic     take;
      data_type data;
   } cell_link_type;

   // command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

FILE: design/hqi_req_if.sv
// ---------------------------------------------------------------------------
// hqi_req_if: input channel of the hybrid sorter
// One beat carries one element and the end-of-set mark.
// ---------------------------------------------------------------------------
interface hqi_req_if;
   logic              valid;
   logic              ready;
   hqi_pkg::data_type value;
   logic              last_in;

   modport source (output valid, output value, output last_in, input ready);
   modport sink   (input valid, input value, input last_in, output ready);
endinterface

FILE: design/hqi_rsp_if.sv
// ---------------------------------------------------------------------------
// hqi_rsp_if: result channel of the hybrid sorter
// One beat carries one sorted element with its last and overflow flags.
// ---------------------------------------------------------------------------
interface hqi_rsp_if;
   logic              valid;
   logic              ready;
   hqi_pkg::data_type sorted_value;
   logic              last_out;
   logic              overflow;

   modport source (output valid, output sorted_value, output last_out, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_value, input last_out, input overflow,
                   output ready);
endinterface

FILE: design/hqi_cell.sv
// ---------------------------------------------------------------------------
// hqi_cell: one slot of the sorting chain
// Holds one element. On insert, the lowest cell that is empty or whose value
// exceeds the new one takes it and every cell above takes its lower neighbor's
// element. On shift, each cell takes its upper neighbor's element.
// ---------------------------------------------------------------------------
module hqi_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  hqi_pkg::cell_ctrl_type ctrl,
   input  hqi_pkg::data_type      new_value,
   input  hqi_pkg::cell_link_type lower,
   input  hqi_pkg::cell_link_type upper,
   output hqi_pkg::cell_link_type self_link
);

   logic              valid_ff, valid_in;
   hqi_pkg::data_type data_ff, data_in;
   logic              take;

   // claim the new element when empty or holding a larger value
   assign take = !valid_ff || (new_value < data_ff);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctrl.shift) begin
         valid_in = upper.valid;
         data_in  = upper.data;
      end else if (ctrl.insert && take) begin
         if (lower.take) begin
            valid_in = lower.valid;
            data_in  = lower.data;
         end else begin
            valid_in = 1'b1;
            data_in  = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign self_link.valid = valid_ff;
   assign self_link.take  = take;
   assign self_link.data  = data_ff;

endmodule

FILE: design/hybrid_quicksort_insertion.sv
// ---------------------------------------------------------------------------
// hybrid_quicksort_insertion: sorter of up to 64 signed elements
// Loads a set into a sorted chain of cells and emits it in ascending order.
//
//   port      | dir | beat contents
//   ----------+-----+----------------------------------------------
//   req_ch    | in  | value, last_in
//   rsp_ch    | out | sorted_value, last_out, overflow
//   csr_*     | in  | insertion_cutoff write (7 bits)
//
// Each element is placed into order as it arrives, by the single
// compare-and-shift step of the cell chain, so loading has no busy state.
// After the last beat, the set drains one element per cycle from the
// bottom cell while rsp_ch.ready is high. Reset (synchronous) empties the
// chain. req_ch.ready is low while a set drains; rsp_ch.ready low holds the
// chain. The order is unique, so the cutoff setting leaves results as is.
// ---------------------------------------------------------------------------
module hybrid_quicksort_insertion (
   input  logic                 clock,
   input  logic                 reset,
   hqi_req_if.sink              req_ch,
   hqi_rsp_if.source            rsp_ch,
   input  logic                 csr_wr_en,
   input  hqi_pkg::cutoff_type  csr_wr_data
);

   localparam int N = hqi_pkg::MAX_ELEMENTS;

   hqi_pkg::state_type     state_ff, state_in;
   hqi_pkg::count_type     count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   hqi_pkg::cell_ctrl_type ctrl;
   hqi_pkg::cell_link_type links [N];
   hqi_pkg::cell_link_type lower_links [N];
   hqi_pkg::cell_link_type upper_links [N];
   logic                   req_beat, rsp_beat, full;

   assign full     = (count_ff == hqi_pkg::count_type'(N));
   assign req_beat = req_ch.valid && req_ch.ready;
   assign rsp_beat = rsp_ch.valid && rsp_ch.ready;

   // handshakes
   assign req_ch.ready        = (state_ff == hqi_pkg::ST_LOAD);
   assign rsp_ch.valid        = (state_ff == hqi_pkg::ST_DRAIN);
   assign rsp_ch.sorted_value = links[0].data;
   assign rsp_ch.last_out     = !links[1].valid;
   assign rsp_ch.overflow     = ovf_ff;

   // insert when room is left, shift out on each result beat
   assign ctrl.insert = req_beat && !full;
   assign ctrl.shift  = rsp_beat;

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      case (state_ff)
         hqi_pkg::ST_LOAD: begin
            if (req_beat) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
               if (req_ch.last_in) begin
                  state_in = hqi_pkg::ST_DRAIN;
               end
            end
         end
         hqi_pkg::ST_DRAIN: begin
            if (rsp_beat && rsp_ch.last_out) begin
               state_in = hqi_pkg::ST_LOAD;
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = hqi_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hqi_pkg::ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // chain of cells, bottom cell holds the smallest element
   for (genvar i = 0; i < N; i++) begin : g_cell
      if (i == 0) begin : g_bottom
         assign lower_links[i] = '0;
      end else begin : g_mid_lo
         assign lower_links[i] = links[i-1];
      end
      if (i == N - 1) begin : g_top
         assign upper_links[i] = '0;
      end else begin : g_mid_hi
         assign upper_links[i] = links[i+1];
      end

      hqi_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .new_value (req_ch.value),
         .lower     (lower_links[i]),
         .upper     (upper_links[i]),
         .self_link (links[i])
      );
   end

endmodule
